### src/sitoa_pkg.sv
`default_nettype none

package sitoa_pkg;

	// Field widths
	localparam int VALUE_W = 32;
	localparam int MAG_W   = 32;
	localparam int CHAR_W  = 6;
	localparam int DIGIT_W = 4;

	// Digit buffer sizing
	localparam int MAX_DIGITS = 10;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	// Divide by ten: floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for any 32-bit x
	localparam int              PROD_W      = 2 * MAG_W;
	localparam logic [MAG_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
	localparam int              RECIP_SHIFT = 35;

	// ASCII codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	// Queue between the front and back parts
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified number
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} item_t;

	// Handshake between queue and back part
	typedef struct packed {
		logic valid;
	} qctl_t;

endpackage

`default_nettype wire

### src/signed_int_to_decimal_ascii_top.sv
`default_nettype none

// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_stall   value[31:0] signed
// out      out  out_valid/out_stall character[5:0], last
//
// A number with D digits (D = 1..10) is divided down after it leaves the
// queue (one registered 32x32 multiply by the reciprocal of ten, then a
// remainder step, per digit); its characters then go out, with an
// eleven-character number the longest. The next value is taken into the
// front stage and the two-entry queue meanwhile.
// arst_n clears all control state at once; no clearing pass is needed.
// out_stall holds the output register; character emission waits until it frees.

module signed_int_to_decimal_ascii_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [sitoa_pkg::VALUE_W-1:0] value,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [sitoa_pkg::CHAR_W-1:0] character,
	output logic                         last
);

	import sitoa_pkg::*;

	logic  push;
	item_t push_item;
	logic  queue_full;
	qctl_t qctl;
	item_t q_item;
	logic  q_pop;

	// Accept and classify sign and magnitude
	sitoa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	// Decouple the front from the converter
	sitoa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.ctl_out   (qctl),
		.pop       (q_pop),
		.pop_item  (q_item)
	);

	// Convert to digits and emit characters
	sitoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qctl      (qctl),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

### src/sitoa_front.sv
`default_nettype none

module sitoa_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [sitoa_pkg::VALUE_W-1:0] value,
	output logic                          push,
	output sitoa_pkg::item_t              push_item,
	input  wire                           queue_full
);

	import sitoa_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       load;
	logic       neg;
	logic [MAG_W-1:0] mag;

	// Split sign and magnitude; the most negative value maps to 2^31 exactly
	always_comb begin
		neg = value[VALUE_W-1];
		mag = neg ? MAG_W'(~value + VALUE_W'(1)) : MAG_W'(value);
	end

	// Hand the staged item to the queue when it has room
	assign push      = valid_s1 && !queue_full;
	assign push_item = item_s1;
	assign load      = !valid_s1 || !queue_full;
	assign in_stall  = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the classified transaction
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1.neg <= neg;
			item_s1.mag <= mag;
		end
	end

endmodule

`default_nettype wire

### src/sitoa_queue.sv
`default_nettype none

module sitoa_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  sitoa_pkg::item_t      push_item,
	output logic                  full,
	output sitoa_pkg::qctl_t      ctl_out,
	input  wire                   pop,
	output sitoa_pkg::item_t      pop_item
);

	import sitoa_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full          = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign ctl_out.valid = (count_q != '0);
	assign do_push       = push && !full;
	assign do_pop        = pop && ctl_out.valid;
	assign pop_item      = mem_q[rptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### src/sitoa_back.sv
`default_nettype none

module sitoa_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sitoa_pkg::qctl_t             qctl,
	input  sitoa_pkg::item_t             q_item,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [sitoa_pkg::CHAR_W-1:0] character,
	output logic                         last
);

	import sitoa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]         state_q;
	logic               neg_q;
	logic [MAG_W-1:0]   work_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CNT_W-1:0]   ndig_q;
	logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];
	logic               ovalid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               out_free;
	logic [MAG_W-1:0]   quo;
	logic [MAG_W-1:0]   rem_full;
	logic [CNT_W-1:0]   ndig_inc;
	logic [CNT_W-1:0]   ndig_dec;
	logic               conv_done;
	logic               emit_char;
	logic               emit_sign;

	assign out_free = !ovalid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && qctl.valid;

	// Quotient and remainder of one divide-by-ten step
	always_comb begin
		quo       = MAG_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
		rem_full  = work_q - (quo << 3) - (quo << 1);
		ndig_inc  = ndig_q + CNT_W'(1);
		ndig_dec  = ndig_q - CNT_W'(1);
		conv_done = (quo == '0) || (ndig_inc == CNT_W'(MAX_DIGITS));
		emit_sign = (state_q == ST_SIGN) && out_free;
		emit_char = (state_q == ST_EMIT) && out_free;
	end

	// Sequence: take, divide digit by digit, then emit sign and digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ndig_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (qctl.valid) begin
						ndig_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					ndig_q <= ndig_inc;
					if (conv_done) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						ndig_q <= ndig_dec;
						if (ndig_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working magnitude, product and digit buffer
	always_ff @(posedge clk) begin
		if (q_pop) begin
			neg_q  <= q_item.neg;
			work_q <= q_item.mag;
		end else if (state_q == ST_DIV) begin
			work_q <= quo;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(work_q) * PROD_W'(RECIP_TEN);
		end
		if (state_q == ST_DIV) begin
			digits_q[ndig_q[IDX_W-1:0]] <= rem_full[DIGIT_W-1:0];
		end
	end

	// Output register valid: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_sign || emit_char) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit_sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (emit_char) begin
			char_q <= ASCII_ZERO + CHAR_W'(digits_q[ndig_dec[IDX_W-1:0]]);
			last_q <= (ndig_q == CNT_W'(1));
		end
	end

	assign out_valid = ovalid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

### tb/tb_signed_int_to_decimal_ascii_top.sv
`default_nettype none

module tb_signed_int_to_decimal_ascii_top;

	import sitoa_pkg::*;

	localparam int RANDOM_ITEMS = 350;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PERCENT = 19;
	// no idling on either side while this range of values is taken
	localparam int STEADY_FROM  = 150;
	localparam int STEADY_TO    = 230;
	localparam int REPORT_LIMIT = 40;

	// one emitted character as seen on the output channel
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [VALUE_W-1:0] value = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [CHAR_W-1:0] character;
	logic last;

	logic [VALUE_W-1:0] value_queue [$];
	text_char_t expected_chars [$];
	text_char_t oldest_char;
	int values_taken = 0;
	int total_items = 0;
	int error_count = 0;
	int cycle_count = 0;

	// edges of the range, sign changes, digit-count boundaries, bit patterns
	int directed_values [] = '{
		0, 1, -1, 9, 10, -10, 99, 100, -100, 999999999, 1000000000, -1000000000,
		2000000000, 123456789, -123456789, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
		32'h55555555, 32'hAAAAAAAA, 7, -9
	};

	signed_int_to_decimal_ascii_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		if (error_count < REPORT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// expected text of one number: optional minus, then digits, most significant first
	function automatic void predict_text(input logic [VALUE_W-1:0] v);
		logic [VALUE_W:0] mag;
		logic [DIGIT_W-1:0] digits [MAX_DIGITS];
		int n;
		text_char_t c;
		n = 0;
		mag = v[VALUE_W-1] ? ((33'd1 << VALUE_W) - {1'b0, v}) : {1'b0, v};
		do begin
			digits[n] = DIGIT_W'(mag % 10);
			n++;
			mag = mag / 10;
		end while (mag != 0 && n < MAX_DIGITS);
		if (v[VALUE_W-1]) begin
			c.character = ASCII_MINUS;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		for (int i = n - 1; i >= 0; i--) begin
			c.character = ASCII_ZERO + digits[i];
			c.last = (i == 0);
			expected_chars.push_back(c);
		end
	endfunction

	// mostly a random digit count, some tiny values, some raw 32-bit words
	function automatic logic [VALUE_W-1:0] pick_value();
		int kind;
		int ndig;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mag;
		logic neg;
		kind = $urandom_range(0, 99);
		if (kind < 25)
			return $urandom;
		neg = 1'($urandom_range(0, 1));
		if (kind < 40) begin
			mag = $urandom_range(0, 20);
		end else begin
			ndig = $urandom_range(1, 10);
			lo = 1;
			repeat (ndig - 1) lo = lo * 10;
			hi = lo * 10 - 1;
			if (ndig == 1)
				lo = 0;
			if (hi > 64'd2147483647)
				hi = neg ? 64'd2147483648 : 64'd2147483647;
			mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
		end
		return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
	endfunction

	function automatic logic take_break();
		if (values_taken >= STEADY_FROM && values_taken < STEADY_TO)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PERCENT;
	endfunction

	// drive input transactions; hold the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_text(value);
				values_taken <= values_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (value_queue.size() > 0 && !take_break()) begin
					in_valid <= 1'b1;
					value <= value_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// check output transactions against the oldest expected character
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %0d last %0b",
						character, last));
				end else begin
					oldest_char = expected_chars.pop_front();
					if (character !== oldest_char.character)
						report_mismatch($sformatf("character %0d, want %0d",
							character, oldest_char.character));
					if (last !== oldest_char.last)
						report_mismatch($sformatf("last %0b, want %0b",
							last, oldest_char.last));
				end
			end
			out_stall <= take_break();
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout with %0d characters outstanding", expected_chars.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		foreach (directed_values[i])
			value_queue.push_back(VALUE_W'(directed_values[i]));
		repeat (RANDOM_ITEMS) value_queue.push_back(pick_value());
		total_items = value_queue.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every value to be taken, then for its text to come out
		while (values_taken < total_items) @(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
